/* rtl/core/dtlv_pkg.sv */
`default_nettype none

package dtlv_pkg;

   localparam int unsigned MAX_LENGTH_OCTETS = 4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;

   localparam logic [7:0] TAG_NUM_MASK    = 8'h1F;
   localparam logic [7:0] LEN_LONG_FLAG   = 8'h80;
   localparam logic [7:0] CONSTRUCTED_BIT = 8'h20;
   localparam logic [7:0] ANY_TAG         = 8'h00;

endpackage

`default_nettype wire

/* rtl/core/der_tlv_header_parser.sv */
// A transaction passes through the input register, then its result is held in the result register that drives rsp_.
// Throughput: one header byte per cycle; the req_ side stalls only while a result waits.
// A byte that completes or rejects a header gives one result; other bytes give none.
// Reset is synchronous, active high: it drops both valid flags and returns the parser to idle.
`default_nettype none

module der_tlv_header_parser
   import dtlv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_read,
   input  wire logic [7:0]  req_expect_tag,
   input  wire logic        req_require_constructed,
   input  wire logic [31:0] req_bytes_available,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_tag_out,
   output logic [31:0]      rsp_value_length,
   output logic [2:0]       rsp_header_length
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_LONG
   } phase_type;

   localparam logic [6:0] MaxOctets = 7'(MAX_LENGTH_OCTETS);

   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_start_ff;
   logic [7:0]  in_expect_ff;
   logic        in_cons_ff;
   logic [31:0] in_avail_ff;

   phase_type   phase_ff,       phase_in;
   logic [7:0]  tag_seen_ff,    tag_seen_in;
   logic [31:0] length_acc_ff,  length_acc_in;
   logic [3:0]  octets_left_ff, octets_left_in;
   logic [31:0] bytes_left_ff,  bytes_left_in;
   logic [2:0]  header_cnt_ff,  header_cnt_in;
   logic        first_oct_ff,   first_oct_in;

   logic        rsp_valid_ff,   rsp_valid_in;
   logic [1:0]  rsp_status_ff,  rsp_status_in;
   logic [7:0]  rsp_tag_ff,     rsp_tag_in;
   logic [31:0] rsp_len_ff,     rsp_len_in;
   logic [2:0]  rsp_hdr_ff,     rsp_hdr_in;

   logic        advance;
   logic        emit;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      logic [6:0]  n_oct;
      logic [31:0] acc_next;
      logic [31:0] left_next;
      logic [3:0]  oct_next;

      phase_in       = phase_ff;
      tag_seen_in    = tag_seen_ff;
      length_acc_in  = length_acc_ff;
      octets_left_in = octets_left_ff;
      bytes_left_in  = bytes_left_ff;
      header_cnt_in  = header_cnt_ff;
      first_oct_in   = first_oct_ff;
      emit           = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_tag_in     = '0;
      rsp_len_in     = '0;
      rsp_hdr_in     = '0;
      n_oct          = in_data_ff[6:0];
      acc_next       = {length_acc_ff[23:0], in_data_ff};
      left_next      = bytes_left_ff - 32'd1;
      oct_next       = octets_left_ff - 4'd1;

      if (in_start_ff) begin
         phase_in = PH_IDLE;
         if (in_cons_ff && ((in_expect_ff & CONSTRUCTED_BIT) == ANY_TAG)) begin
            emit          = 1'b1;
            rsp_status_in = ST_INVALID;
         end else if ((in_avail_ff < 32'd2)
                      || ((in_data_ff & TAG_NUM_MASK) == TAG_NUM_MASK)
                      || ((in_expect_ff != ANY_TAG) && (in_data_ff != in_expect_ff))) begin
            emit          = 1'b1;
            rsp_status_in = ST_MALFORMED;
         end else begin
            tag_seen_in    = in_data_ff;
            bytes_left_in  = in_avail_ff - 32'd1;
            header_cnt_in  = 3'd1;
            length_acc_in  = '0;
            octets_left_in = '0;
            first_oct_in   = 1'b0;
            phase_in       = PH_FIRST;
         end
      end else begin
         unique case (phase_ff)
            PH_FIRST: begin
               bytes_left_in = left_next;
               header_cnt_in = 3'd2;
               if (in_data_ff < LEN_LONG_FLAG) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
                  if (left_next < {24'd0, in_data_ff}) begin
                     rsp_status_in = ST_MALFORMED;
                  end else begin
                     rsp_tag_in = tag_seen_ff;
                     rsp_len_in = {24'd0, in_data_ff};
                     rsp_hdr_in = 3'd2;
                  end
               end else if ((in_data_ff == LEN_LONG_FLAG) || (n_oct > MaxOctets)
                            || (left_next < {25'd0, n_oct})) begin
                  emit          = 1'b1;
                  phase_in      = PH_IDLE;
                  rsp_status_in = ST_MALFORMED;
               end else begin
                  octets_left_in = n_oct[3:0];
                  length_acc_in  = '0;
                  first_oct_in   = 1'b1;
                  phase_in       = PH_LONG;
               end
            end
            PH_LONG: begin
               if ((first_oct_ff && (in_data_ff == 8'h00))
                   || (length_acc_ff[31:24] != 8'h00)) begin
                  emit          = 1'b1;
                  phase_in      = PH_IDLE;
                  rsp_status_in = ST_MALFORMED;
               end else begin
                  first_oct_in   = 1'b0;
                  length_acc_in  = acc_next;
                  if (bytes_left_ff != 32'd0) begin
                     bytes_left_in = left_next;
                  end
                  header_cnt_in  = header_cnt_ff + 3'd1;
                  if (octets_left_ff != 4'd0) begin
                     octets_left_in = oct_next;
                  end
                  if (octets_left_in == 4'd0) begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                     if ((acc_next < 32'h80) || (bytes_left_in < acc_next)) begin
                        rsp_status_in = ST_MALFORMED;
                     end else begin
                        rsp_tag_in = tag_seen_ff;
                        rsp_len_in = acc_next;
                        rsp_hdr_in = header_cnt_in;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         octets_left_ff <= '0;
         first_oct_ff   <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (req_valid && req_ready) begin
            in_data_ff   <= req_data_byte;
            in_start_ff  <= req_start_read;
            in_expect_ff <= req_expect_tag;
            in_cons_ff   <= req_require_constructed;
            in_avail_ff  <= req_bytes_available;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            tag_seen_ff    <= tag_seen_in;
            length_acc_ff  <= length_acc_in;
            octets_left_ff <= octets_left_in;
            bytes_left_ff  <= bytes_left_in;
            header_cnt_ff  <= header_cnt_in;
            first_oct_ff   <= first_oct_in;
            if (emit) begin
               rsp_status_ff <= rsp_status_in;
               rsp_tag_ff    <= rsp_tag_in;
               rsp_len_ff    <= rsp_len_in;
               rsp_hdr_ff    <= rsp_hdr_in;
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_tag_out       = rsp_tag_ff;
   assign rsp_value_length  = rsp_len_ff;
   assign rsp_header_length = rsp_hdr_ff;

   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK)
         |-> (rsp_tag_ff == 8'h00) && (rsp_len_ff == 32'd0) && (rsp_hdr_ff == 3'd0))
      else $error("error result carries nonzero fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == ST_OK) || (rsp_status_ff == ST_MALFORMED)
                       || (rsp_status_ff == ST_INVALID))
      else $error("undefined status code");

   a_ok_header_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_OK) && (rsp_hdr_ff == 3'd2)
         |-> (rsp_len_ff < 32'h80))
      else $error("short-form header with long length");

   a_long_has_octets: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LONG) |-> (octets_left_ff != 4'd0))
      else $error("long-form phase with no length octets pending");

   a_no_emit_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("pending result lost");

endmodule

`default_nettype wire
